// File: hw/rtl/cht_pkg.sv
package cht_pkg;
	localparam int HOME_SLOTS = 256;
	localparam int TOTAL_SLOTS = HOME_SLOTS + (HOME_SLOTS >> 3);
	localparam int IW = $clog2(TOTAL_SLOTS + 1);
	localparam logic [IW-1:0] END_LINK = IW'(TOTAL_SLOTS);

	localparam logic [1:0] REQ_PUT = 2'd0;
	localparam logic [1:0] REQ_GET = 2'd1;
	localparam logic [1:0] REQ_DEL = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_DELETED   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	typedef logic [IW-1:0] idx_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] key;
		logic [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] value_out;
	} rsp_t;

	function automatic idx_t home_of(logic [31:0] k);
		logic [63:0] x;
		logic [63:0] m;
		x = {32'd0, k};
		m = x ^ (x << 8) ^ (x << 16) ^ (x << 24);
		return IW'(m % 64'(HOME_SLOTS));
	endfunction
endpackage

// File: hw/rtl/cht_if.sv
interface cht_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/coalesced_hash_table.sv
// Coalesced hash table with a cellar: 256 home slots and 32 cellar slots, each holding a valid
// bit, key, value and next link in one synchronous entry memory with a registered read. One
// request is handled at a time. The request is taken in the idle state; every memory read then
// passes an address state and a check state, and every memory write its own write state; the
// result is then offered and held until taken, and only then is the next request taken.
// A get, a delete or an update walks the key's chain, one read per entry visited. A put of
// a new key into an occupied home adds a top-down free-slot scan, one read per slot
// inspected and, when the home occupant belongs to another chain, a walk of that chain to the
// occupant's predecessor, one read per entry; it ends with two or three writes. A delete
// ends with one or two writes, plus one read when the chain head pulls its successor in.
// After reset a clearing pass writes each of the 288 slots empty before the first request.
module coalesced_hash_table (
	input logic clk,
	input logic arst_n,
	cht_if.sink   req,
	cht_if.source rsp
);
	import cht_pkg::*;

	typedef struct packed {
		logic        vld;
		logic [31:0] k;
		logic [31:0] v;
		idx_t        nx;
	} ent_t;

	localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_CHK = 3'd3,
		S_WR = 3'd4, S_OUT = 3'd5;
	localparam logic [1:0] P_LOOK = 2'd0, P_SCAN = 2'd1, P_PRED = 2'd2, P_SUCC = 2'd3;
	localparam ent_t EMPTY = '{1'b0, 32'd0, 32'd0, END_LINK};
	localparam idx_t LAST = IW'(TOTAL_SLOTS - 1);

	ent_t mem [TOTAL_SLOTS];
	ent_t rd_q;
	logic we;
	idx_t wa;
	ent_t wd;

	logic [2:0] st_q;
	logic [1:0] ph_q;
	req_t r_q;
	idx_t cur_q, prev_q, home_q, spare_q, end_q, cnt_q;
	logic has_prev_q;
	ent_t c_q, p_q, h_q;
	idx_t wadr_q [3];
	ent_t wdat_q [3];
	logic [1:0] wi_q, wl_q;
	rsp_t out_q;

	logic hit, more;
	ent_t home_ent;

	assign hit = rd_q.vld && rd_q.k == r_q.key;
	assign more = rd_q.nx < END_LINK && cnt_q < END_LINK;
	assign home_ent = (cnt_q == '0) ? rd_q : h_q;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[cur_q];
	end

	always_comb begin
		we = 1'b0; wa = wadr_q[wi_q]; wd = wdat_q[wi_q];
		case (st_q)
			S_CLR: begin
				we = 1'b1; wa = cnt_q; wd = EMPTY;
			end
			S_WR: we = 1'b1;
			default: ;
		endcase
	end

	assign req.ready = st_q == S_IDLE;
	assign rsp.valid = st_q == S_OUT;
	assign rsp.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; ph_q <= P_LOOK; cnt_q <= '0; cur_q <= '0;
			wi_q <= '0; wl_q <= '0;
		end else begin
			case (st_q)
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) st_q <= S_IDLE;
				end
				S_IDLE: if (req.valid) begin
					r_q <= req.data;
					cur_q <= home_of(req.data.key);
					home_q <= home_of(req.data.key);
					has_prev_q <= 1'b0; cnt_q <= '0; ph_q <= P_LOOK; wi_q <= '0;
					out_q <= '{ST_NOT_FOUND, 32'd0};
					if (req.data.req_type inside {REQ_PUT, REQ_GET, REQ_DEL}) st_q <= S_RD;
					else st_q <= S_OUT;
				end
				S_RD: st_q <= S_CHK;
				S_CHK: begin
					case (ph_q)
						P_LOOK: begin
							c_q <= rd_q;
							if (cnt_q == '0) h_q <= rd_q;
							if (hit) begin
								case (r_q.req_type)
									REQ_GET: begin
										out_q <= '{ST_FOUND, rd_q.v}; st_q <= S_OUT;
									end
									REQ_PUT: begin
										wadr_q[0] <= cur_q;
										wdat_q[0] <= '{1'b1, rd_q.k, r_q.value_in, rd_q.nx};
										wl_q <= 2'd0;
										out_q <= '{ST_UPDATED, 32'd0}; st_q <= S_WR;
									end
									default: begin
										out_q <= '{ST_DELETED, 32'd0};
										if (has_prev_q) begin
											wadr_q[0] <= prev_q;
											wdat_q[0] <= '{p_q.vld, p_q.k, p_q.v, rd_q.nx};
											wadr_q[1] <= cur_q; wdat_q[1] <= EMPTY;
											wl_q <= 2'd1; st_q <= S_WR;
										end else if (rd_q.nx < END_LINK) begin
											// head pulls its successor in
											cur_q <= rd_q.nx; ph_q <= P_SUCC; st_q <= S_RD;
										end else begin
											wadr_q[0] <= cur_q; wdat_q[0] <= EMPTY;
											wl_q <= 2'd0; st_q <= S_WR;
										end
									end
								endcase
							end else if (more) begin
								p_q <= rd_q; prev_q <= cur_q; has_prev_q <= 1'b1;
								cur_q <= rd_q.nx; cnt_q <= cnt_q + 1'b1; st_q <= S_RD;
							end else if (r_q.req_type != REQ_PUT) begin
								st_q <= S_OUT;
							end else if (!home_ent.vld) begin
								wadr_q[0] <= home_q;
								wdat_q[0] <= '{1'b1, r_q.key, r_q.value_in, END_LINK};
								wl_q <= 2'd0;
								out_q <= '{ST_INSERTED, 32'd0}; st_q <= S_WR;
							end else begin
								// chain end kept for the append
								end_q <= cur_q; cur_q <= LAST; ph_q <= P_SCAN; st_q <= S_RD;
							end
						end
						P_SCAN: begin
							if (!rd_q.vld) begin
								spare_q <= cur_q;
								out_q <= '{ST_INSERTED, 32'd0};
								if (home_of(h_q.k) != home_q) begin
									cur_q <= home_of(h_q.k); cnt_q <= '0;
									ph_q <= P_PRED; st_q <= S_RD;
								end else begin
									wadr_q[0] <= end_q;
									wdat_q[0] <= '{c_q.vld, c_q.k, c_q.v, cur_q};
									wadr_q[1] <= cur_q;
									wdat_q[1] <= '{1'b1, r_q.key, r_q.value_in, END_LINK};
									wl_q <= 2'd1; st_q <= S_WR;
								end
							end else if (cur_q == '0) begin
								out_q <= '{ST_FULL, 32'd0}; st_q <= S_OUT;
							end else begin
								cur_q <= cur_q - 1'b1; st_q <= S_RD;
							end
						end
						P_PRED: begin
							if (rd_q.nx < END_LINK && rd_q.nx != home_q && cnt_q < END_LINK) begin
								cur_q <= rd_q.nx; cnt_q <= cnt_q + 1'b1; st_q <= S_RD;
							end else begin
								// move the occupant out, relink its predecessor
								wadr_q[0] <= home_q;
								wdat_q[0] <= '{1'b1, r_q.key, r_q.value_in, END_LINK};
								wadr_q[1] <= spare_q;
								wdat_q[1] <= '{1'b1, h_q.k, h_q.v, h_q.nx};
								wadr_q[2] <= cur_q;
								wdat_q[2] <= '{rd_q.vld, rd_q.k, rd_q.v, spare_q};
								wl_q <= (rd_q.nx == home_q) ? 2'd2 : 2'd1;
								st_q <= S_WR;
							end
						end
						default: begin
							wadr_q[0] <= home_q; wdat_q[0] <= rd_q;
							wadr_q[1] <= cur_q; wdat_q[1] <= EMPTY;
							wl_q <= 2'd1; st_q <= S_WR;
						end
					endcase
				end
				S_WR: begin
					if (wi_q == wl_q) st_q <= S_OUT;
					else wi_q <= wi_q + 1'b1;
				end
				S_OUT: if (rsp.ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/cht_checker.sv
module cht_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [2:0] rsp_status
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(req_ready && rsp_valid))
		else $error("ready while result pending");
	a_after: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item taken");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status <= 3'd5)
		else $error("bad status");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("result dropped");
endmodule

bind coalesced_hash_table cht_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.data.status)
);
